// File: rtl/core/ramped_gain_soft_clipper_top_assert.svh
// Assertion macros for the ramped gain soft clipper.
`ifndef RAMPED_GAIN_SOFT_CLIPPER_TOP_ASSERT_SVH
`define RAMPED_GAIN_SOFT_CLIPPER_TOP_ASSERT_SVH

// Condition implies check in the same cycle.
`define RGSC_ASSERT_SAME(lbl, cond, chk) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
    else $error("rgsc assertion failed");

// Condition implies check in the next cycle.
`define RGSC_ASSERT_NEXT(lbl, cond, chk) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
    else $error("rgsc assertion failed");

`endif

// File: rtl/core/rgsc_pkg.sv
`timescale 1ns / 1ps
package rgsc_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int TAB_W            = 31;
  localparam int TAB_AW           = $clog2(TANH_TABLE_DEPTH + 1);

  localparam int MUL_AW = 34;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;

  localparam int YM_W  = MUL_PW - 16;
  localparam int RES_W = YM_W + 1;

  localparam logic [63:0] TANH_H  = (64'd8 << 30) / TANH_TABLE_DEPTH;
  localparam logic [63:0] TANH_H2 = (TANH_H * TANH_H) >> 30;
  localparam logic [63:0] TANH_H3 = (TANH_H2 * TANH_H) >> 30;
  localparam logic [63:0] TANH_H5 = (TANH_H3 * TANH_H2) >> 30;
  localparam logic [63:0] TANH_H7 = (TANH_H5 * TANH_H2) >> 30;
  localparam logic [63:0] TANH_STEP = TANH_H - TANH_H3 / 3 + (2 * TANH_H5) / 15
                                      - (17 * TANH_H7) / 315;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH = 8'd3;

  localparam logic [22:0] SATURATION_RESET = 23'd5242880;

  typedef enum logic [1:0] {
    MODE_CLIP  = 2'd0,
    MODE_UPPER = 2'd1,
    MODE_TANH  = 2'd2,
    MODE_ATANH = 2'd3
  } mode_t;

endpackage

// File: rtl/core/rgsc_if.sv
`timescale 1ns / 1ps
interface rgsc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rgsc_pkg::SAMPLE_BITS-1:0] sample_in;
  logic signed [31:0]                   gain_mod;
  logic                                 start_ramp;
  modport source (output valid, sample_in, gain_mod, start_ramp, input ready);
  modport sink (input valid, sample_in, gain_mod, start_ramp, output ready);
endinterface

interface rgsc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rgsc_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                 ramp_busy;
  modport source (output valid, sample_out, ramp_busy, input ready);
  modport sink (input valid, sample_out, ramp_busy, output ready);
endinterface

interface rgsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rgsc_pkg::CFG_IDX_W-1:0]    index;
  logic [31:0]                       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ramped_gain_soft_clipper_top.sv
`timescale 1ns / 1ps
// In the clip modes an input beat without a ramp start uses only the serial multiplier; a ramp start adds
// a serial division, and a tanh mode can add another, so up to two serial divisions are used per beat.
// A new input beat is accepted only after the previous result has been moved to the output register.
// After reset the tanh table is built with the same serial units, one entry after another,
// and no input beat is accepted until it is done.
`include "ramped_gain_soft_clipper_top_assert.svh"
module ramped_gain_soft_clipper_top (
  input  logic     clk,
  input  logic     rst_n,
  rgsc_in_if.sink  in_ch,
  rgsc_out_if.source out_ch,
  rgsc_cfg_if.sink cfg_ch
);

  localparam int SB     = rgsc_pkg::SAMPLE_BITS;
  localparam int RES_W  = rgsc_pkg::RES_W;
  localparam int YM_W   = rgsc_pkg::YM_W;
  localparam int TAB_W  = rgsc_pkg::TAB_W;
  localparam int TAB_AW = rgsc_pkg::TAB_AW;
  localparam int DEPTH  = rgsc_pkg::TANH_TABLE_DEPTH;

  localparam logic signed [RES_W-1:0] RES_SMAX = RES_W'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [RES_W-1:0] RES_SMIN = -RES_SMAX - RES_W'(1);

  typedef enum logic [17:0] {
    ST_BOOT  = 18'h00001,
    ST_BMUL  = 18'h00002,
    ST_BMULW = 18'h00004,
    ST_BDIVW = 18'h00008,
    ST_IDLE  = 18'h00010,
    ST_RAMP  = 18'h00020,
    ST_RDIVW = 18'h00040,
    ST_STEP  = 18'h00080,
    ST_MOD   = 18'h00100,
    ST_MAG   = 18'h00200,
    ST_MULW  = 18'h00400,
    ST_SHAPE = 18'h00800,
    ST_TDIVW = 18'h01000,
    ST_RDA   = 18'h02000,
    ST_RDB   = 18'h04000,
    ST_RDC   = 18'h08000,
    ST_IMULW = 18'h10000,
    ST_OUT   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  rgsc_pkg::mode_t mode_r;
  logic [22:0]     sat_r;
  logic [31:0]     tg_r;
  logic [15:0]     rl_r;

  logic signed [SB-1:0]    x_r, x_nxt;
  logic signed [31:0]      mod_r, mod_nxt;
  logic [47:0]             cur_r, cur_nxt;
  logic [47:0]             inc_r, inc_nxt;
  logic [16:0]             steps_r, steps_nxt;
  logic                    dneg_r, dneg_nxt;
  logic signed [48:0]      csum_r, csum_nxt;
  logic                    gneg_r, gneg_nxt;
  logic [YM_W-1:0]         ym_r, ym_nxt;
  logic                    end_r, end_nxt;
  logic [15:0]             fr_r, fr_nxt;
  logic [TAB_W-1:0]        a_r, a_nxt;
  logic [TAB_AW-1:0]       addr_r, addr_nxt;
  logic [TAB_W-1:0]        t_r, t_nxt;
  logic [TAB_AW-1:0]       bcnt_r, bcnt_nxt;
  logic signed [RES_W-1:0] res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SB-1:0]    out_sample_r, out_sample_nxt;
  logic                    out_busy_r, out_busy_nxt;

  logic [TAB_W-1:0] tab_mem [DEPTH+1];
  logic [TAB_W-1:0] tab_rd_r;
  logic             tab_we;
  logic [TAB_AW-1:0] tab_waddr;
  logic [TAB_W-1:0] tab_wdata;

  logic                        mul_start, mul_done;
  logic [rgsc_pkg::MUL_AW-1:0] mul_a;
  logic [rgsc_pkg::MUL_BW-1:0] mul_b;
  logic [rgsc_pkg::MUL_PW-1:0] mul_p;
  logic                        div_start, div_done;
  logic [rgsc_pkg::DIV_NW-1:0] div_num, div_q;
  logic [rgsc_pkg::DIV_DW-1:0] div_den;

  logic in_acc;
  logic yneg;

  rgsc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  rgsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.ramp_busy  = out_busy_r;

  assign yneg = (gneg_r != x_r[SB-1]) && (ym_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rgsc_pkg::MODE_CLIP;
      sat_r  <= rgsc_pkg::SATURATION_RESET;
      tg_r   <= '0;
      rl_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rgsc_pkg::CFG_MODE:        mode_r <= rgsc_pkg::mode_t'(cfg_ch.data[1:0]);
        rgsc_pkg::CFG_SATURATION:  sat_r  <= cfg_ch.data[22:0];
        rgsc_pkg::CFG_TARGET_GAIN: tg_r   <= cfg_ch.data;
        rgsc_pkg::CFG_RAMP_LENGTH: rl_r   <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [48:0]      diff;
    logic [48:0]             dmag;
    logic [16:0]             n;
    logic signed [48:0]      sum;
    logic [48:0]             cmag;
    logic [SB-1:0]           xm;
    logic signed [RES_W-1:0] lin;
    logic signed [RES_W-1:0] s_ext;
    logic [rgsc_pkg::MUL_PW-1:0] rnd;
    logic [TAB_W:0]          v;
    logic [TAB_W:0]          vr;
    logic [TAB_W-1:0]        bd;
    logic [47:0]             idx;

    state_nxt      = state_r;
    x_nxt          = x_r;
    mod_nxt        = mod_r;
    cur_nxt        = cur_r;
    inc_nxt        = inc_r;
    steps_nxt      = steps_r;
    dneg_nxt       = dneg_r;
    csum_nxt       = csum_r;
    gneg_nxt       = gneg_r;
    ym_nxt         = ym_r;
    end_nxt        = end_r;
    fr_nxt         = fr_r;
    a_nxt          = a_r;
    addr_nxt       = addr_r;
    t_nxt          = t_r;
    bcnt_nxt       = bcnt_r;
    res_nxt        = res_r;
    out_sample_nxt = out_sample_r;
    out_busy_nxt   = out_busy_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    tab_we         = 1'b0;
    tab_waddr      = '0;
    tab_wdata      = '0;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;
    vr             = '0;

    diff  = $signed({tg_r[31], tg_r, 16'h0000}) - $signed({cur_r[47], cur_r});
    dmag  = diff[48] ? 49'(-diff) : 49'(diff);
    n     = (rl_r == '0) ? 17'd1 : {1'b0, rl_r};
    sum   = $signed({cur_r[47], cur_r}) + $signed({mod_r[31], mod_r, 16'h0000});
    cmag  = csum_r[48] ? 49'(-csum_r) : 49'(csum_r);
    xm    = x_r[SB-1] ? SB'(-x_r) : SB'(x_r);
    lin   = yneg ? -$signed({1'b0, ym_r}) : $signed({1'b0, ym_r});
    s_ext = $signed(RES_W'(sat_r));
    rnd   = mul_p + rgsc_pkg::MUL_PW'(32768);
    v     = {1'b0, a_r} + {1'b0, rnd[TAB_W+15:16]};
    bd    = (tab_rd_r < a_r) ? '0 : (tab_rd_r - a_r);
    idx   = div_q[63:16];

    unique case (state_r)
      ST_BOOT: begin
        tab_we    = 1'b1;
        tab_waddr = '0;
        tab_wdata = '0;
        t_nxt     = '0;
        bcnt_nxt  = '0;
        state_nxt = ST_BMUL;
      end
      ST_BMUL: begin
        mul_start = 1'b1;
        mul_a     = rgsc_pkg::MUL_AW'(t_r);
        mul_b     = rgsc_pkg::MUL_BW'(rgsc_pkg::TANH_STEP);
        state_nxt = ST_BMULW;
      end
      ST_BMULW: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = (64'(t_r) + rgsc_pkg::TANH_STEP) << 30;
          div_den   = 32'h4000_0000 + mul_p[61:30];
          state_nxt = ST_BDIVW;
        end
      end
      ST_BDIVW: begin
        if (div_done) begin
          tab_we    = 1'b1;
          tab_waddr = bcnt_r + 1'b1;
          tab_wdata = div_q[TAB_W-1:0];
          t_nxt     = div_q[TAB_W-1:0];
          if (bcnt_r == TAB_AW'(DEPTH - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            bcnt_nxt  = bcnt_r + 1'b1;
            state_nxt = ST_BMUL;
          end
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt     = in_ch.sample_in;
          mod_nxt   = in_ch.gain_mod;
          state_nxt = in_ch.start_ramp ? ST_RAMP : ST_STEP;
        end
      end
      ST_RAMP: begin
        div_start = 1'b1;
        div_num   = 64'(dmag);
        div_den   = 32'(n);
        dneg_nxt  = diff[48];
        steps_nxt = n;
        state_nxt = ST_RDIVW;
      end
      ST_RDIVW: begin
        if (div_done) begin
          inc_nxt   = dneg_r ? 48'(-div_q[47:0]) : div_q[47:0];
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (steps_r != '0) begin
          cur_nxt   = cur_r + inc_r;
          steps_nxt = steps_r - 1'b1;
        end
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (!cur_r[47] && (cur_r != '0)) begin
          csum_nxt = sum[48] ? '0 : sum;
        end else begin
          csum_nxt = (!sum[48] && (sum != '0)) ? '0 : sum;
        end
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        gneg_nxt  = csum_r[48];
        mul_start = 1'b1;
        mul_a     = rgsc_pkg::MUL_AW'(cmag[48:16]);
        mul_b     = rgsc_pkg::MUL_BW'(xm);
        state_nxt = ST_MULW;
      end
      ST_MULW: begin
        if (mul_done) begin
          ym_nxt    = rnd[rgsc_pkg::MUL_PW-1:16];
          state_nxt = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        end_nxt = 1'b0;
        if (mode_r == rgsc_pkg::MODE_CLIP) begin
          res_nxt   = (lin > s_ext) ? s_ext : ((lin < -s_ext) ? -s_ext : lin);
          state_nxt = ST_OUT;
        end else if (mode_r == rgsc_pkg::MODE_UPPER) begin
          res_nxt   = (lin > s_ext) ? s_ext : lin;
          state_nxt = ST_OUT;
        end else if ((mode_r == rgsc_pkg::MODE_ATANH) && x_r[SB-1]) begin
          res_nxt   = lin;
          state_nxt = ST_OUT;
        end else if (ym_r == '0) begin
          res_nxt   = '0;
          state_nxt = ST_OUT;
        end else if (ym_r >= YM_W'({sat_r, 3'b000})) begin
          end_nxt   = 1'b1;
          addr_nxt  = TAB_AW'(DEPTH);
          state_nxt = ST_RDA;
        end else begin
          div_start = 1'b1;
          div_num   = (64'(ym_r) * 64'(DEPTH)) << 16;
          div_den   = 32'({sat_r, 3'b000});
          state_nxt = ST_TDIVW;
        end
      end
      ST_TDIVW: begin
        if (div_done) begin
          if (idx >= 48'(DEPTH)) begin
            addr_nxt = TAB_AW'(DEPTH - 1);
            fr_nxt   = 16'hFFFF;
          end else begin
            addr_nxt = idx[TAB_AW-1:0];
            fr_nxt   = div_q[15:0];
          end
          state_nxt = ST_RDA;
        end
      end
      ST_RDA: begin
        if (!end_r) begin
          addr_nxt = addr_r + 1'b1;
        end
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        if (end_r) begin
          vr        = {1'b0, tab_rd_r} + (TAB_W+1)'(1024);
          res_nxt   = yneg ? -RES_W'(vr[TAB_W:11]) : RES_W'(vr[TAB_W:11]);
          state_nxt = ST_OUT;
        end else begin
          a_nxt     = tab_rd_r;
          state_nxt = ST_RDC;
        end
      end
      ST_RDC: begin
        mul_start = 1'b1;
        mul_a     = rgsc_pkg::MUL_AW'(bd);
        mul_b     = rgsc_pkg::MUL_BW'(fr_r);
        state_nxt = ST_IMULW;
      end
      ST_IMULW: begin
        if (mul_done) begin
          vr        = v + (TAB_W+1)'(1024);
          res_nxt   = yneg ? -RES_W'(vr[TAB_W:11]) : RES_W'(vr[TAB_W:11]);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (res_r > RES_SMAX) begin
            out_sample_nxt = RES_SMAX[SB-1:0];
          end else if (res_r < RES_SMIN) begin
            out_sample_nxt = RES_SMIN[SB-1:0];
          end else begin
            out_sample_nxt = res_r[SB-1:0];
          end
          out_busy_nxt = (steps_r != '0);
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_BOOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BOOT;
      cur_r       <= '0;
      inc_r       <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
      bcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      inc_r       <= inc_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
      bcnt_r      <= bcnt_nxt;
    end
    x_r          <= x_nxt;
    mod_r        <= mod_nxt;
    dneg_r       <= dneg_nxt;
    csum_r       <= csum_nxt;
    gneg_r       <= gneg_nxt;
    ym_r         <= ym_nxt;
    end_r        <= end_nxt;
    fr_r         <= fr_nxt;
    a_r          <= a_nxt;
    addr_r       <= addr_nxt;
    t_r          <= t_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
    out_busy_r   <= out_busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rd_r <= tab_mem[addr_r];
  end

  `RGSC_ASSERT_NEXT(a_gain_only_steps, state_r != ST_STEP, $stable(cur_r))
  `RGSC_ASSERT_SAME(a_steps_bound, 1'b1, steps_r <= 17'd65536)
  `RGSC_ASSERT_NEXT(a_out_drains, out_valid_r && out_ch.ready && state_r != ST_OUT,
                    !out_valid_r)

endmodule

// File: rtl/core/rgsc_mul.sv
`timescale 1ns / 1ps
module rgsc_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rgsc_pkg::MUL_AW-1:0] op_a,
  input  logic [rgsc_pkg::MUL_BW-1:0] op_b,
  output logic                        done,
  output logic [rgsc_pkg::MUL_PW-1:0] prod
);

  localparam int CW = $clog2(rgsc_pkg::MUL_BW + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [rgsc_pkg::MUL_AW-1:0] a_r, a_nxt;
  logic [rgsc_pkg::MUL_PW-1:0] p_r, p_nxt;
  logic [rgsc_pkg::MUL_AW:0]   psum;

  // One multiplier bit per cycle: add the multiplicand, then shift right.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    p_nxt    = p_r;
    psum     = {1'b0, p_r[rgsc_pkg::MUL_PW-1:rgsc_pkg::MUL_BW]}
             + (p_r[0] ? {1'b0, a_r} : '0);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(rgsc_pkg::MUL_BW);
      a_nxt    = op_a;
      p_nxt    = {{rgsc_pkg::MUL_AW{1'b0}}, op_b};
    end else if (busy_r) begin
      p_nxt   = {psum, p_r[rgsc_pkg::MUL_BW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// File: rtl/core/rgsc_div.sv
`timescale 1ns / 1ps
module rgsc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rgsc_pkg::DIV_NW-1:0] num,
  input  logic [rgsc_pkg::DIV_DW-1:0] den,
  output logic                        done,
  output logic [rgsc_pkg::DIV_NW-1:0] quo
);

  localparam int CW = $clog2(rgsc_pkg::DIV_NW + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [rgsc_pkg::DIV_DW-1:0] d_r, d_nxt;
  logic [rgsc_pkg::DIV_DW-1:0] rem_r, rem_nxt;
  logic [rgsc_pkg::DIV_NW-1:0] q_r, q_nxt;
  logic [rgsc_pkg::DIV_DW:0]   shifted;
  logic [rgsc_pkg::DIV_DW:0]   trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    shifted  = {rem_r, q_r[rgsc_pkg::DIV_NW-1]};
    trial    = shifted - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(rgsc_pkg::DIV_NW);
      d_nxt    = den;
      rem_nxt  = '0;
      q_nxt    = num;
    end else if (busy_r) begin
      if (!trial[rgsc_pkg::DIV_DW]) begin
        rem_nxt = trial[rgsc_pkg::DIV_DW-1:0];
        q_nxt   = {q_r[rgsc_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[rgsc_pkg::DIV_DW-1:0];
        q_nxt   = {q_r[rgsc_pkg::DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// File: dv/rgsc_tb_if.sv
`timescale 1ns / 1ps
module rgsc_tb_clkgen (
  output logic clk
);
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end
endmodule

// File: dv/ramped_gain_soft_clipper_top_test.sv
`timescale 1ns / 1ps
module ramped_gain_soft_clipper_top_test;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               busy;
  } shaped_t;

  class clip_scoreboard;
    logic [1:0]  mode;
    logic [22:0] sat;
    logic [31:0] target;
    logic [15:0] rlen;
    logic [47:0] gain;
    logic [47:0] incr;
    logic [16:0] steps;
    logic [63:0] tab [0:256];
    shaped_t     pending [$];
    int          errors;

    function void reset_state();
      logic [63:0] t;
      mode = rgsc_pkg::MODE_CLIP;
      sat = rgsc_pkg::SATURATION_RESET;
      target = '0;
      rlen = '0;
      gain = '0;
      incr = '0;
      steps = '0;
      errors = 0;
      tab[0] = 0;
      for (int i = 0; i < 256; i++) begin
        t = tab[i];
        tab[i + 1] = ((t + rgsc_pkg::TANH_STEP) << 30)
                     / ((64'd1 << 30) + ((t * rgsc_pkg::TANH_STEP) >> 30));
      end
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] d);
      case (idx)
        rgsc_pkg::CFG_MODE: mode = d[1:0];
        rgsc_pkg::CFG_SATURATION: sat = d[22:0];
        rgsc_pkg::CFG_TARGET_GAIN: target = d;
        rgsc_pkg::CFG_RAMP_LENGTH: rlen = d[15:0];
        default: ;
      endcase
    endfunction

    function longint tanh_q19(longint mag, bit neg);
      longint unsigned v, p, idx, fr, a, b, r, m;
      if (mag == 0) return 0;
      m = mag;
      if (m >= longint'(sat) * 8) begin
        v = tab[256];
      end else begin
        p = ((m * 256) << 16) / (longint'(sat) * 8);
        idx = p >> 16;
        fr = p & 16'hFFFF;
        if (idx >= 256) begin
          idx = 255;
          fr = 16'hFFFF;
        end
        a = tab[idx];
        b = tab[idx + 1];
        if (b < a) b = a;
        v = a + (((b - a) * fr + 32768) >> 16);
      end
      r = (v + 1024) >> 11;
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function void note_input(logic signed [23:0] x, logic signed [31:0] gmod, logic st);
      longint n, diff, cur, sum, g, gm, xm, ym, lin, y, s;
      bit gneg, xneg, yneg;
      shaped_t e;
      if (st) begin
        n = (rlen == 0) ? 1 : rlen;
        diff = longint'($signed(target)) * 65536 - longint'($signed(gain));
        incr = 48'(diff / n);
        steps = 17'(n);
      end
      if (steps > 0) begin
        gain = gain + incr;
        steps = steps - 1;
      end
      cur = longint'($signed(gain));
      sum = cur + longint'(gmod) * 65536;
      if (cur > 0) g = sum < 0 ? 0 : sum;
      else g = sum > 0 ? 0 : sum;
      g = g / 65536;
      gneg = g < 0;
      gm = gneg ? -g : g;
      xneg = x < 0;
      xm = xneg ? -longint'(x) : longint'(x);
      ym = (gm * xm + 32768) >>> 16;
      yneg = (gneg != xneg) && ym != 0;
      lin = yneg ? -ym : ym;
      s = sat;
      case (mode)
        rgsc_pkg::MODE_CLIP: y = lin > s ? s : (lin < -s ? -s : lin);
        rgsc_pkg::MODE_UPPER: y = lin > s ? s : lin;
        rgsc_pkg::MODE_TANH: y = tanh_q19(ym, yneg);
        default: y = xneg ? lin : tanh_q19(ym, yneg);
      endcase
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      e.sample = 24'(y);
      e.busy = steps != 0;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [23:0] smp, logic busy);
      shaped_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result expected none actual %0d/%0b", $time, smp, busy);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (smp !== e.sample) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.sample, smp);
        errors++;
      end
      if (busy !== e.busy) begin
        $display("%0t: ramp_busy expected %0b actual %0b", $time, e.busy, busy);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  rgsc_in_if  in_ch ();
  rgsc_out_if out_ch ();
  rgsc_cfg_if cfg_ch ();
  clip_scoreboard sb;
  longint cycles;
  bit     calm;
  int     holdoff;

  rgsc_tb_clkgen u_clk (.clk(clk));

  ramped_gain_soft_clipper_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.gain_mod = '0;
    in_ch.start_ramp = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.sample_in, in_ch.gain_mod, in_ch.start_ramp);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.sample_out, out_ch.ramp_busy);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (holdoff > 0) begin
      holdoff--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_cfg(logic [7:0] idx, logic [31:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [23:0] x, logic signed [31:0] gm, logic st);
    while (!calm && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= x;
    in_ch.gain_mod <= gm;
    in_ch.start_ramp <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_cfg(int k);
    logic [31:0] sv;
    write_cfg(rgsc_pkg::CFG_MODE, $urandom);
    case ($urandom_range(3))
      0: sv = 0;
      1: sv = 32'h7FFFFF;
      default: sv = $urandom_range(32'h7FFFFF, 1) | ($urandom << 23);
    endcase
    write_cfg(rgsc_pkg::CFG_SATURATION, sv);
    case (k % 4)
      0: write_cfg(rgsc_pkg::CFG_TARGET_GAIN, 32'h80000000);
      1: write_cfg(rgsc_pkg::CFG_TARGET_GAIN, 32'h7FFFFFFF);
      default: write_cfg(rgsc_pkg::CFG_TARGET_GAIN,
                         $signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
    case (k % 5)
      0: write_cfg(rgsc_pkg::CFG_RAMP_LENGTH, 0);
      1: write_cfg(rgsc_pkg::CFG_RAMP_LENGTH, 32'hFFFF);
      default: write_cfg(rgsc_pkg::CFG_RAMP_LENGTH, $urandom_range(40) | ($urandom << 16));
    endcase
    if ($urandom_range(3) == 0) write_cfg(8'd4 + 8'($urandom_range(251)), $urandom);
  endtask

  function automatic logic signed [31:0] rand_mod();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h80000000;
      2: return 32'h7FFFFFFF;
      default: return $signed($urandom_range(1 << 17)) - (1 << 16);
    endcase
  endfunction

  initial begin
    logic [1:0] m;
    sb = new();
    sb.reset_state();
    cycles = 0;
    calm = 1'b0;
    holdoff = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int md = 0; md < 4; md++) begin
      m = 2'(md);
      write_cfg(rgsc_pkg::CFG_MODE, {30'd0, m});
      write_cfg(rgsc_pkg::CFG_SATURATION, md == 3 ? 32'd0 : 32'h00280000);
      write_cfg(rgsc_pkg::CFG_TARGET_GAIN, 32'h00020000);
      write_cfg(rgsc_pkg::CFG_RAMP_LENGTH, md == 0 ? 32'd0 : 32'd3);
      send_sample(24'sh7FFFFF, 32'sd0, 1'b1);
      send_sample(-24'sh800000, 32'sd0, 1'b0);
      send_sample(24'sd0, 32'h7FFFFFFF, 1'b1);
      send_sample(24'sh100000, 32'h80000000, 1'b0);
      send_sample(-24'sh040000, 32'h00010000, 1'b0);
      drain();
    end

    for (int k = 0; k < 12; k++) begin
      random_cfg(k);
      calm = (k == 3);
      if (k == 6) holdoff = 2000;
      for (int i = 0; i < 150; i++)
        send_sample(24'($urandom), rand_mod(), $urandom_range(15) == 0);
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
